// ===== hw/rtl/hashed_timing_wheel_top_macros.svh =====
// Assertion macros used by the checker of the timing wheel.
`ifndef HASHED_TIMING_WHEEL_TOP_MACROS_SVH
`define HASHED_TIMING_WHEEL_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTW_ASSERT_SAME(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("timing wheel check failed");

// The consequent must hold in the cycle after the antecedent.
`define HTW_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("timing wheel check failed");

`endif

// ===== hw/rtl/htw_pkg.sv =====
`timescale 1ns / 1ps

package htw_pkg;

    localparam int WHEEL_SLOTS = 64;
    localparam int MAX_TIMERS  = 32;
    localparam int SLOT_W      = $clog2(WHEEL_SLOTS);
    localparam int IDX_W       = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W       = $clog2(MAX_TIMERS + 1);
    localparam int CLIENT_W    = 16;
    localparam int DELAY_W     = 32;
    localparam int TICKS_W     = DELAY_W - 1;
    localparam int ROT_W       = TICKS_W - SLOT_W;
    localparam int DIV_CNT_W   = $clog2(TICKS_W);
    localparam int INTERVAL_W  = 16;
    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);

    typedef enum logic [1:0] {
        ACT_ADD,
        ACT_ADJUST,
        ACT_DELETE,
        ACT_TICK
    } t_action;

    typedef enum logic [2:0] {
        ST_EXPIRED,
        ST_DONE,
        ST_FULL,
        ST_IGNORED,
        ST_NOT_FOUND
    } t_status;

    typedef struct packed {
        t_action              action;
        logic [CLIENT_W-1:0]  client;
        logic                 ignore;
        logic [TICKS_W-1:0]   ticks;
    } t_cmd;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_START,
        B_SCAN,
        B_SCAN_END,
        B_TICK,
        B_EMIT
    } t_back_state;

endpackage

// ===== hw/rtl/htw_front.sv =====
`timescale 1ns / 1ps

module htw_front import htw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [1:0]            i_action,
    input  logic [CLIENT_W-1:0]   i_client_id,
    input  logic [DELAY_W-1:0]    i_delay,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [INTERVAL_W-1:0] i_cfg_data,
    output logic                  o_q_push,
    input  logic                  i_q_full,
    output t_cmd                  o_q_data
);

    t_front_state          r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    logic [INTERVAL_W-1:0] r_tick, r_rem, n_rem;
    logic [TICKS_W-1:0]    r_dvd, n_dvd;
    logic [DIV_CNT_W-1:0]  r_cnt, n_cnt;
    logic [INTERVAL_W-1:0] w_divisor;
    logic [INTERVAL_W:0]   w_trial, w_diff;
    logic                  w_ge, w_neg, w_timed;

    assign w_divisor   = (r_tick == '0) ? INTERVAL_W'(1) : r_tick;
    assign w_trial     = {r_rem, r_dvd[TICKS_W-1]};
    assign w_ge        = w_trial >= {1'b0, w_divisor};
    assign w_diff      = w_trial - {1'b0, w_divisor};
    assign w_neg       = i_delay[DELAY_W-1];
    assign w_timed     = (t_action'(i_action) == ACT_ADD) || (t_action'(i_action) == ACT_ADJUST);
    assign o_full      = (r_state != F_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_q_data    = r_cmd;

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_rem    = r_rem;
        n_dvd    = r_dvd;
        n_cnt    = r_cnt;
        o_q_push = 1'b0;
        case (r_state)
            F_IDLE: begin
                if (i_push) begin
                    n_cmd.action = t_action'(i_action);
                    n_cmd.client = i_client_id;
                    n_cmd.ignore = w_neg && w_timed;
                    n_cmd.ticks  = TICKS_W'(1);
                    n_dvd        = i_delay[TICKS_W-1:0];
                    n_rem        = '0;
                    n_cnt        = '0;
                    if (w_timed && !w_neg && (i_delay != '0)) begin
                        n_state = F_DIV;
                    end else begin
                        n_state = F_PUSH;
                    end
                end
            end
            F_DIV: begin
                n_rem       = w_ge ? w_diff[INTERVAL_W-1:0] : w_trial[INTERVAL_W-1:0];
                n_dvd       = {r_dvd[TICKS_W-2:0], 1'b0};
                n_cmd.ticks = {r_cmd.ticks[TICKS_W-2:0], w_ge};
                if (r_cnt == DIV_CNT_W'(TICKS_W - 1)) begin
                    n_state = F_PUSH;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            F_PUSH: begin
                o_q_push = 1'b1;
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_tick  <= INTERVAL_W'(1);
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_tick <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_cnt <= n_cnt;
    end

endmodule

// ===== hw/rtl/htw_cmd_fifo.sv =====
`timescale 1ns / 1ps

module htw_cmd_fifo import htw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_full,
    input  t_cmd i_data,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_data
);

    t_cmd                r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wptr, r_rptr;
    logic [CMDQ_PTR_W:0]   r_count;
    logic                  w_wr, w_rd;

    assign o_full  = (r_count == (CMDQ_PTR_W + 1)'(CMDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/htw_back.sv =====
`timescale 1ns / 1ps

module htw_back import htw_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    output logic                o_q_pop,
    input  logic                i_q_empty,
    input  t_cmd                i_q_data,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [2:0]          o_status,
    output logic [CLIENT_W-1:0] o_expired_client,
    output logic                o_last
);

    // Timer table.
    logic                r_valid  [MAX_TIMERS];
    logic [CLIENT_W-1:0] r_client [MAX_TIMERS];
    logic [SLOT_W-1:0]   r_slot   [MAX_TIMERS];
    logic [ROT_W-1:0]    r_rot    [MAX_TIMERS];
    logic [IDX_W-1:0]    r_stamp  [MAX_TIMERS];
    logic                r_pend   [MAX_TIMERS];

    t_back_state         r_state, n_state;
    t_cmd                r_cmd, n_cmd;
    logic [SLOT_W-1:0]   r_cur_slot, n_cur_slot;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [IDX_W-1:0]    r_idx, n_idx, r_best, n_best;
    logic [SLOT_W+IDX_W-1:0] r_best_key, n_best_key;
    logic                r_found, n_found, r_any, n_any;
    logic [CNT_W-1:0]    r_rank, n_rank;
    t_status             r_emit, n_emit;
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    logic [CLIENT_W-1:0] r_out_client, n_out_client;
    logic                r_out_last, n_out_last;

    logic                w_ins_en, w_new_en, w_rem_en, w_dec_en, w_pend_load, w_pend_clr;
    logic [IDX_W-1:0]    w_free_idx, w_hit_idx, w_rem_idx;
    logic [IDX_W-1:0]    w_rem_stamp;
    logic                w_hit_any, w_out_free;
    logic [SLOT_W-1:0]   w_new_slot;
    logic [ROT_W-1:0]    w_new_rot;
    logic [SLOT_W+IDX_W-1:0] w_key;

    assign w_new_slot = r_cur_slot + r_cmd.ticks[SLOT_W-1:0];
    assign w_new_rot  = r_cmd.ticks[TICKS_W-1:SLOT_W];
    assign w_key      = {r_slot[r_idx], r_stamp[r_idx]};
    assign w_out_free = !r_out_valid || i_pop;

    assign o_empty          = !r_out_valid;
    assign o_status         = r_out_status;
    assign o_expired_client = r_out_client;
    assign o_last           = r_out_last;

    always_comb begin
        w_free_idx = '0;
        w_hit_idx  = '0;
        w_hit_any  = 1'b0;
        for (int j = MAX_TIMERS - 1; j >= 0; j--) begin
            if (!r_valid[j]) begin
                w_free_idx = IDX_W'(j);
            end
            if (r_valid[j] && (r_slot[j] == r_cur_slot) &&
                (r_stamp[j] == r_rank[IDX_W-1:0])) begin
                w_hit_idx = IDX_W'(j);
                w_hit_any = 1'b1;
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_cur_slot   = r_cur_slot;
        n_count      = r_count;
        n_idx        = r_idx;
        n_best       = r_best;
        n_best_key   = r_best_key;
        n_found      = r_found;
        n_any        = r_any;
        n_rank       = r_rank;
        n_emit       = r_emit;
        n_out_valid  = r_out_valid && !i_pop;
        n_out_status = r_out_status;
        n_out_client = r_out_client;
        n_out_last   = r_out_last;
        o_q_pop      = 1'b0;
        w_ins_en     = 1'b0;
        w_new_en     = 1'b0;
        w_rem_en     = 1'b0;
        w_dec_en     = 1'b0;
        w_pend_load  = 1'b0;
        w_pend_clr   = 1'b0;
        w_rem_idx    = r_best;
        w_rem_stamp  = r_best_key[IDX_W-1:0];
        case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop     = 1'b1;
                    w_pend_load = 1'b1;
                    n_cmd       = i_q_data;
                    n_idx       = '0;
                    n_found     = 1'b0;
                    n_any       = 1'b0;
                    n_rank      = '0;
                    n_state     = B_START;
                end
            end
            B_START: begin
                if (r_cmd.ignore) begin
                    n_emit  = ST_IGNORED;
                    n_state = B_EMIT;
                end else begin
                    case (r_cmd.action)
                        ACT_ADD: begin
                            if (r_count == CNT_W'(MAX_TIMERS)) begin
                                n_emit = ST_FULL;
                            end else begin
                                w_ins_en = 1'b1;
                                n_count  = r_count + 1'b1;
                                n_emit   = ST_DONE;
                            end
                            n_state = B_EMIT;
                        end
                        ACT_TICK: begin
                            n_state = B_TICK;
                        end
                        default: begin
                            n_state = B_SCAN;
                        end
                    endcase
                end
            end
            B_SCAN: begin
                if (r_pend[r_idx] && (!r_found || (w_key < r_best_key))) begin
                    n_best     = r_idx;
                    n_best_key = w_key;
                    n_found    = 1'b1;
                end
                if (r_idx == IDX_W'(MAX_TIMERS - 1)) begin
                    n_state = B_SCAN_END;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            B_SCAN_END: begin
                if (!r_found) begin
                    n_emit  = r_any ? ST_DONE : ST_NOT_FOUND;
                    n_state = B_EMIT;
                end else if (r_cmd.action == ACT_DELETE) begin
                    w_rem_en = 1'b1;
                    n_count  = r_count - 1'b1;
                    n_emit   = ST_DONE;
                    n_state  = B_EMIT;
                end else begin
                    w_new_en   = 1'b1;
                    w_pend_clr = 1'b1;
                    n_any      = 1'b1;
                    n_idx      = '0;
                    n_found    = 1'b0;
                    n_state    = B_SCAN;
                end
            end
            B_TICK: begin
                if (r_rank >= r_count) begin
                    n_cur_slot = r_cur_slot + 1'b1;
                    n_emit     = ST_DONE;
                    n_state    = B_EMIT;
                end else if (!w_hit_any) begin
                    n_rank = r_rank + 1'b1;
                end else if (r_rot[w_hit_idx] != '0) begin
                    w_dec_en = 1'b1;
                    n_rank   = r_rank + 1'b1;
                end else if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_EXPIRED;
                    n_out_client = r_client[w_hit_idx];
                    n_out_last   = 1'b0;
                    w_rem_en     = 1'b1;
                    w_rem_idx    = w_hit_idx;
                    w_rem_stamp  = r_rank[IDX_W-1:0];
                    n_count      = r_count - 1'b1;
                end
            end
            B_EMIT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_emit;
                    n_out_client = r_cmd.client;
                    n_out_last   = 1'b1;
                    n_state      = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_cur_slot  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < MAX_TIMERS; j++) begin
                r_valid[j] <= 1'b0;
            end
        end else begin
            r_state     <= n_state;
            r_cur_slot  <= n_cur_slot;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            for (int j = 0; j < MAX_TIMERS; j++) begin
                if (w_ins_en && (IDX_W'(j) == w_free_idx)) begin
                    r_valid[j] <= 1'b1;
                end else if (w_rem_en && (IDX_W'(j) == w_rem_idx)) begin
                    r_valid[j] <= 1'b0;
                end
            end
        end
    end

    // Every live stamp is a recency rank; inserts, moves and removals keep them dense.
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_TIMERS; j++) begin
            if (w_ins_en) begin
                if (IDX_W'(j) == w_free_idx) begin
                    r_stamp[j]  <= '0;
                    r_client[j] <= r_cmd.client;
                    r_slot[j]   <= w_new_slot;
                    r_rot[j]    <= w_new_rot;
                end else if (r_valid[j]) begin
                    r_stamp[j] <= r_stamp[j] + 1'b1;
                end
            end
            if (w_new_en) begin
                if (IDX_W'(j) == r_best) begin
                    r_stamp[j] <= '0;
                    r_slot[j]  <= w_new_slot;
                    r_rot[j]   <= w_new_rot;
                end else if (r_valid[j] && (r_stamp[j] < r_best_key[IDX_W-1:0])) begin
                    r_stamp[j] <= r_stamp[j] + 1'b1;
                end
            end
            if (w_rem_en && r_valid[j] && (r_stamp[j] > w_rem_stamp)) begin
                r_stamp[j] <= r_stamp[j] - 1'b1;
            end
            if (w_dec_en && (IDX_W'(j) == w_hit_idx)) begin
                r_rot[j] <= r_rot[j] - 1'b1;
            end
            if (w_pend_load) begin
                r_pend[j] <= r_valid[j] && (r_client[j] == i_q_data.client);
            end else if (w_pend_clr && (IDX_W'(j) == r_best)) begin
                r_pend[j] <= 1'b0;
            end
        end
        r_cmd        <= n_cmd;
        r_idx        <= n_idx;
        r_best       <= n_best;
        r_best_key   <= n_best_key;
        r_found      <= n_found;
        r_any        <= n_any;
        r_rank       <= n_rank;
        r_emit       <= n_emit;
        r_out_status <= n_out_status;
        r_out_client <= n_out_client;
        r_out_last   <= n_out_last;
    end

endmodule

// ===== hw/rtl/hashed_timing_wheel_top.sv =====
`timescale 1ns / 1ps

// Hashed timing wheel with 64 slots and room for 32 timers. Requests enter through a queue
// interface (push/full) and results leave through another (empty/pop); each request gives one
// result, and a tick gives one result per expired timer followed by a final one with last set.
// The front end converts an add or adjust delay into ticks with a bit-serial divider and holds
// full while it works on a request. The back end handles an add or an ignored request directly,
// makes one pass over the timer table for a delete, one pass per matching timer plus a final
// one for an adjust, and one step per live timer for a tick, each result waiting while the
// output is not taken. The front end takes the next request while the back end is still busy,
// with up to two requests queued between them.
module hashed_timing_wheel_top import htw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            i_action,
    input  logic [CLIENT_W-1:0]   i_client_id,
    input  logic signed [DELAY_W-1:0] i_delay,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [INTERVAL_W-1:0] i_cfg_data,
    input  logic                  pop,
    output logic                  empty,
    output logic [2:0]            o_status,
    output logic [CLIENT_W-1:0]   o_expired_client,
    output logic                  o_last
);

    logic w_fq_push, w_fq_full, w_bq_pop, w_bq_empty;
    t_cmd w_fq_data, w_bq_data;

    htw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_action    (i_action),
        .i_client_id (i_client_id),
        .i_delay     (i_delay),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_q_push    (w_fq_push),
        .i_q_full    (w_fq_full),
        .o_q_data    (w_fq_data)
    );

    htw_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fq_push),
        .o_full  (w_fq_full),
        .i_data  (w_fq_data),
        .i_pop   (w_bq_pop),
        .o_empty (w_bq_empty),
        .o_data  (w_bq_data)
    );

    htw_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .o_q_pop          (w_bq_pop),
        .i_q_empty        (w_bq_empty),
        .i_q_data         (w_bq_data),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_status         (o_status),
        .o_expired_client (o_expired_client),
        .o_last           (o_last)
    );

endmodule

// ===== hw/rtl/htw_checker.sv =====
`timescale 1ns / 1ps
`include "hashed_timing_wheel_top_macros.svh"

module htw_checker import htw_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  pop,
    input logic                  empty,
    input logic [2:0]            o_status,
    input logic [CLIENT_W-1:0]   o_expired_client,
    input logic                  o_last
);

    `HTW_ASSERT_NEXT(a_reset_empty, i_clk, !i_rst_n, empty)
    `HTW_ASSERT_SAME(a_partial_is_expiry, i_clk, i_rst_n && !empty && !o_last,
                     o_status == ST_EXPIRED)
    `HTW_ASSERT_SAME(a_expiry_not_final, i_clk, i_rst_n && !empty && (o_status == ST_EXPIRED),
                     !o_last)
    `HTW_ASSERT_NEXT(a_result_held, i_clk, i_rst_n && !empty && !pop,
                     !i_rst_n || (!empty && $stable(o_status) &&
                     $stable(o_expired_client) && $stable(o_last)))

endmodule

bind hashed_timing_wheel_top htw_checker u_htw_checker (.*);
